// ===== hw/rtl/wabd_pkg.sv =====
// Shared types and constants for the window average band detector.
// No dependencies; imported by the core and the top level.

package wabd_pkg;

   localparam int LIMIT_W   = 19;
   localparam int SUM_OUT_W = 19;
   localparam int LAYER_W   = 16;

   localparam logic [LIMIT_W-1:0] LOW_LIMIT_RESET  = 19'd93618;
   localparam logic [LIMIT_W-1:0] HIGH_LIMIT_RESET = 19'd117021;

   // Configuration register indexes
   typedef enum logic [0:0] {
      CSR_LOW_LIMIT  = 1'b0,
      CSR_HIGH_LIMIT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_FILLING = 2'd0,
      ST_DONE    = 2'd1,
      ST_ABORT   = 2'd2,
      ST_SLIDING = 2'd3
   } status_type;

   typedef struct packed {
      status_type           status;
      logic [SUM_OUT_W-1:0] window_sum;
      logic [LAYER_W-1:0]   layer_count;
   } result_type;

endpackage

// ===== hw/rtl/wabd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module wabd_ram #(
   parameter int WIDTH = 14,
   parameter int DEPTH = 20
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/wabd_core.sv =====
// Window state, running sum and band classification for one transaction.
// Depends on wabd_pkg and wabd_ram (sample window storage).

module wabd_core
   import wabd_pkg::*;
#(
   parameter int WINDOW_LEN  = 20,
   parameter int SAMPLE_BITS = 14
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  logic [SAMPLE_BITS-1:0] sample,
   input  logic [LIMIT_W-1:0]     low_limit,
   input  logic [LIMIT_W-1:0]     high_limit,
   output result_type             result
);

   localparam int IDX_W   = $clog2(WINDOW_LEN);
   localparam int CNT_W   = $clog2(WINDOW_LEN + 1);
   localparam int FULL_W  = $clog2(WINDOW_LEN * ((1 << SAMPLE_BITS) - 1) + 1);
   localparam int CMP_W   = (FULL_W > LIMIT_W) ? FULL_W : LIMIT_W;

   logic [IDX_W-1:0]   oldest_ff, oldest_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [CMP_W-1:0]   sum_ff, sum_in;
   logic [LAYER_W-1:0] comp_ff, comp_in;
   logic               byp_hit_ff, byp_hit_in;
   logic [SAMPLE_BITS-1:0] byp_data_ff;

   logic                   wr_en;
   logic [IDX_W:0]         wr_pos;
   logic [IDX_W-1:0]       wr_addr;
   logic [SAMPLE_BITS-1:0] rd_data;
   logic [SAMPLE_BITS-1:0] oldest_val;
   logic [CNT_W-1:0]       fill_a;
   logic [CMP_W-1:0]       sum_a;
   logic [CMP_W-1:0]       lo_ext, hi_ext;
   logic [IDX_W-1:0]       oldest_next;
   status_type             status;

   // Write slot is (oldest + fill) mod window; both operands are below the window length.
   always_comb begin
      wr_pos = (IDX_W+1)'(oldest_ff) + (IDX_W+1)'(fill_ff);
      if (wr_pos >= (IDX_W+1)'(WINDOW_LEN)) begin
         wr_pos = wr_pos - (IDX_W+1)'(WINDOW_LEN);
      end
      wr_addr = wr_pos[IDX_W-1:0];
   end

   assign oldest_next = (oldest_ff == IDX_W'(WINDOW_LEN - 1)) ? '0 : oldest_ff + 1'b1;
   assign lo_ext      = CMP_W'(low_limit);
   assign hi_ext      = CMP_W'(high_limit);
   // RAM read data is registered; a write to the slot being fetched is forwarded
   assign oldest_val  = byp_hit_ff ? byp_data_ff : rd_data;

   always_comb begin
      wr_en  = 1'b0;
      fill_a = fill_ff;
      sum_a  = sum_ff;
      if (fill_ff != CNT_W'(WINDOW_LEN)) begin
         wr_en  = fire;
         fill_a = fill_ff + 1'b1;
         sum_a  = sum_ff + CMP_W'(sample);
      end

      oldest_in = oldest_ff;
      fill_in   = fill_ff;
      sum_in    = sum_ff;
      comp_in   = comp_ff;
      if (fill_a != CNT_W'(WINDOW_LEN)) begin
         status  = ST_FILLING;
         fill_in = fill_a;
         sum_in  = sum_a;
      end else if (sum_a >= lo_ext && sum_a <= hi_ext) begin
         status    = ST_DONE;
         oldest_in = '0;
         fill_in   = '0;
         sum_in    = '0;
         comp_in   = comp_ff + 1'b1;
      end else if (sum_a < lo_ext) begin
         status    = ST_ABORT;
         oldest_in = '0;
         fill_in   = '0;
         sum_in    = '0;
      end else begin
         status    = ST_SLIDING;
         oldest_in = oldest_next;
         fill_in   = CNT_W'(WINDOW_LEN - 1);
         sum_in    = sum_a - CMP_W'(oldest_val);
      end

      if (!fire) begin
         oldest_in = oldest_ff;
         fill_in   = fill_ff;
         sum_in    = sum_ff;
         comp_in   = comp_ff;
      end

      byp_hit_in = wr_en && (wr_addr == oldest_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff  <= '0;
         fill_ff    <= '0;
         sum_ff     <= '0;
         comp_ff    <= '0;
         byp_hit_ff <= 1'b0;
      end else begin
         oldest_ff  <= oldest_in;
         fill_ff    <= fill_in;
         sum_ff     <= sum_in;
         comp_ff    <= comp_in;
         byp_hit_ff <= byp_hit_in;
      end
      byp_data_ff <= sample;
   end

   wabd_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (WINDOW_LEN)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (sample),
      .rd_addr (oldest_in),
      .rd_data (rd_data)
   );

   assign result.status      = status;
   assign result.window_sum  = sum_a[SUM_OUT_W-1:0];
   assign result.layer_count = comp_in;

endmodule

// ===== hw/rtl/window_average_band_detector_top.sv =====
// Top level of the window average band detector: input stage, limit
// registers, result register. Depends on wabd_pkg and wabd_core.
//
//  channel  | direction | ports                                   | accepted when
//  ---------+-----------+-----------------------------------------+------------------------
//  request  | in        | req_valid, req_stall, req_raw_sample    | req_valid & !req_stall
//  response | out       | rsp_valid, rsp_stall, rsp_status,       | rsp_valid & !rsp_stall
//           |           | rsp_window_sum, rsp_layer_count         |
//  csr      | in        | csr_write_enable, csr_index,            | csr_write_enable
//           |           | csr_write_data                          |
//
// One transaction per cycle sustained while rsp_stall is low; the path runs through the input
// register, then the window update and band compare into the result register.
// The window RAM reads one slot per cycle, the oldest sample, which feeds the window
// update loop. Synchronous reset empties the window at once; no clearing pass.
// A stalled response holds the input stage; req_stall rises only when both are full.

module window_average_band_detector_top
   import wabd_pkg::*;
#(
   parameter int WINDOW_LEN  = 20,
   parameter int SAMPLE_BITS = 14
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [SAMPLE_BITS-1:0] req_raw_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_status,
   output logic [SUM_OUT_W-1:0]   rsp_window_sum,
   output logic [LAYER_W-1:0]     rsp_layer_count,
   input  logic                   csr_write_enable,
   input  logic [0:0]             csr_index,
   input  logic [LIMIT_W-1:0]     csr_write_data
);

   logic                   s1_valid_ff, s1_valid_in;
   logic [SAMPLE_BITS-1:0] s1_sample_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   result_type             rsp_data_ff;
   result_type             core_result;
   logic [LIMIT_W-1:0]     low_limit_ff, high_limit_ff;
   logic                   out_ready;
   logic                   advance;
   logic                   req_take;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_ready;
   assign req_stall = s1_valid_ff && !out_ready;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         low_limit_ff  <= LOW_LIMIT_RESET;
         high_limit_ff <= HIGH_LIMIT_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            unique case (csr_index_type'(csr_index))
               CSR_LOW_LIMIT:  low_limit_ff  <= csr_write_data;
               CSR_HIGH_LIMIT: high_limit_ff <= csr_write_data;
               default: ;
            endcase
         end
      end
      if (req_take) begin
         s1_sample_ff <= req_raw_sample;
      end
      if (advance) begin
         rsp_data_ff <= core_result;
      end
   end

   wabd_core #(
      .WINDOW_LEN  (WINDOW_LEN),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .fire       (advance),
      .sample     (s1_sample_ff),
      .low_limit  (low_limit_ff),
      .high_limit (high_limit_ff),
      .result     (core_result)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_data_ff.status;
   assign rsp_window_sum  = rsp_data_ff.window_sum;
   assign rsp_layer_count = rsp_data_ff.layer_count;

   // held input transaction must not be lost or altered while the result side is blocked
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_ready) |=> (s1_valid_ff && $stable(s1_sample_ff)))
      else $error("input stage dropped or changed while blocked");

   // a new result only ever comes from an occupied input stage
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("result appeared without a transaction in the input stage");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && !s1_valid_ff))
      else $error("pipeline not empty after reset");

endmodule
